[hw/rtl/art_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the arcball rotation tracker.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 14;
  localparam int REG_BITS   = 12;
  // Q2.FRAC value range is [-1, 1], which needs FRAC_BITS + 2 bits
  localparam int QW         = FRAC_BITS + 2;
  localparam int CFG_IDX_W  = 2;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic signed [QW-1:0]   q_t;
  typedef logic [1:0]             op_code_t;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_t;

endpackage

[hw/rtl/art_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_in_if
// Operation channel: pointer move, drag begin, drag end.
// ----------------------------------------------------------------------------
interface art_in_if import art_pkg::*; ();
  logic     valid;
  logic     ready;
  op_code_t op;
  coord_t   pointer_x;
  coord_t   pointer_y;

  modport source (output valid, output op, output pointer_x, output pointer_y,
                  input ready);
  modport sink   (input valid, input op, input pointer_x, input pointer_y,
                  output ready);
endinterface

[hw/rtl/art_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_out_if
// Result channel: conjugate of the current rotation and the drag flag.
// ----------------------------------------------------------------------------
interface art_out_if import art_pkg::*; ();
  logic valid;
  logic ready;
  q_t   rot_x;
  q_t   rot_y;
  q_t   rot_z;
  q_t   rot_w;
  logic is_dragging;

  modport source (output valid, output rot_x, output rot_y, output rot_z,
                  output rot_w, output is_dragging, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                  input rot_w, input is_dragging, output ready);
endinterface

[hw/rtl/arcball_rotation_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcball_rotation_tracker_unit
// Arcball rotation controller in Q2.14: sphere mapping, drag quaternion and
// Hamilton product, driven by a small sequencer over shared units.
// ----------------------------------------------------------------------------
// One transaction is taken when the block is idle. Without an active drag the
// transaction goes straight to the done state, which loads the output
// register once it is free. With a drag, both the down point and the current
// point are mapped onto the ball by one shared shift/compare/subtract unit
// that does restoring division (54 steps) and digit-by-digit square root
// (27 steps): a point inside the ball costs three divides and one root, a
// point outside costs one root and two divides. One shared multiply-accumulate
// unit then forms the drag quaternion and the product with the down rotation.
// A finished result waits in the output register; the next transaction is
// taken while it waits.
module arcball_rotation_tracker_unit import art_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  art_in_if.sink               in_item,
  art_out_if.source            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_BITS-1:0]  cfg_wdata
);

  localparam int DW   = COORD_BITS + 1;            // signed delta
  localparam int SW   = 2 * COORD_BITS + 1;        // dx^2 + dy^2
  localparam int R2W  = 2 * COORD_BITS;            // r^2
  localparam int AW   = SW + 2 * FRAC_BITS + 1;    // shift register, even
  localparam int RTW  = AW / 2;                    // root width
  localparam int DVW  = (RTW > R2W) ? RTW : R2W;   // divisor width
  localparam int RW   = (DVW + 1 > RTW + 2) ? DVW + 1 : RTW + 2;
  localparam int CW   = $clog2(AW);
  localparam int MW   = (QW > DW) ? QW : DW;
  localparam int ACW  = 2 * MW + 2;
  localparam int ONE  = 1 << FRAC_BITS;

  localparam logic signed [ACW-1:0] ONE_A  = ACW'(ONE);
  localparam logic signed [ACW-1:0] HALF_A = ACW'(ONE / 2);
  localparam q_t                    ONE_Q  = QW'(ONE);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_MAC_S, ST_MAC_R, ST_SPLIT, ST_JOB, ST_WAIT,
    ST_PROD, ST_WB, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
    logic       en;
  } term_t;

  // Terms of cross/dot (phase 0: f x t) and Hamilton product (phase 1: d * e)
  function automatic term_t term_tab(input logic ph, input logic [1:0] k,
                                     input logic [1:0] j);
    term_t t;
    t = '0;
    unique case ({ph, k, j})
      5'b0_00_00: t = '{2'd1, 2'd2, 1'b0, 1'b1};
      5'b0_00_01: t = '{2'd2, 2'd1, 1'b1, 1'b1};
      5'b0_01_00: t = '{2'd2, 2'd0, 1'b0, 1'b1};
      5'b0_01_01: t = '{2'd0, 2'd2, 1'b1, 1'b1};
      5'b0_10_00: t = '{2'd0, 2'd1, 1'b0, 1'b1};
      5'b0_10_01: t = '{2'd1, 2'd0, 1'b1, 1'b1};
      5'b0_11_00: t = '{2'd0, 2'd0, 1'b0, 1'b1};
      5'b0_11_01: t = '{2'd1, 2'd1, 1'b0, 1'b1};
      5'b0_11_10: t = '{2'd2, 2'd2, 1'b0, 1'b1};
      5'b1_00_00: t = '{2'd3, 2'd0, 1'b0, 1'b1};
      5'b1_00_01: t = '{2'd0, 2'd3, 1'b0, 1'b1};
      5'b1_00_10: t = '{2'd1, 2'd2, 1'b0, 1'b1};
      5'b1_00_11: t = '{2'd2, 2'd1, 1'b1, 1'b1};
      5'b1_01_00: t = '{2'd3, 2'd1, 1'b0, 1'b1};
      5'b1_01_01: t = '{2'd0, 2'd2, 1'b1, 1'b1};
      5'b1_01_10: t = '{2'd1, 2'd3, 1'b0, 1'b1};
      5'b1_01_11: t = '{2'd2, 2'd0, 1'b0, 1'b1};
      5'b1_10_00: t = '{2'd3, 2'd2, 1'b0, 1'b1};
      5'b1_10_01: t = '{2'd0, 2'd1, 1'b0, 1'b1};
      5'b1_10_10: t = '{2'd1, 2'd0, 1'b1, 1'b1};
      5'b1_10_11: t = '{2'd2, 2'd3, 1'b0, 1'b1};
      5'b1_11_00: t = '{2'd3, 2'd3, 1'b0, 1'b1};
      5'b1_11_01: t = '{2'd0, 2'd0, 1'b1, 1'b1};
      5'b1_11_10: t = '{2'd1, 2'd1, 1'b1, 1'b1};
      5'b1_11_11: t = '{2'd2, 2'd2, 1'b1, 1'b1};
      default:    t = '0;
    endcase
    return t;
  endfunction

  function automatic q_t pick3(input q_t a0, input q_t a1, input q_t a2,
                               input logic [1:0] i);
    q_t v;
    unique case (i)
      2'd0:    v = a0;
      2'd1:    v = a1;
      default: v = a2;
    endcase
    return v;
  endfunction

  // add half, floor, clamp to [-1, 1]
  function automatic q_t round_q(input logic signed [ACW-1:0] v);
    logic signed [ACW-1:0] t;
    logic signed [ACW-1:0] s;
    q_t r;
    t = v + HALF_A;
    s = t >>> FRAC_BITS;
    if (s > ONE_A)       r = ONE_Q;
    else if (s < -ONE_A) r = -ONE_Q;
    else                 r = s[QW-1:0];
    return r;
  endfunction

  // configuration
  coord_t              cx_r, cy_r;
  logic [REG_BITS-1:0] rad_r;
  logic [REG_BITS-1:0] r_eff;

  // architectural state
  logic   drag_r;
  coord_t now_x_r, now_y_r, down_x_r, down_y_r;
  q_t     down_rot_r [4];
  q_t     now_rot_r  [4];

  // sequencer
  state_t     state_r;
  logic       pt_r;
  logic       inside_r;
  logic [1:0] job_r;
  logic       phase_r;
  logic [1:0] k_r, j_r;

  // point mapping
  logic signed [DW-1:0] dx_r, dy_r;
  logic [SW-1:0]        s_r;
  logic [R2W-1:0]       r2_r;
  logic [RTW-1:0]       n_r;
  q_t                   ball_r [2][3];
  q_t                   d_r [4];

  // shared divide / square-root unit
  logic           unit_busy_r;
  logic           unit_sqrt_r;
  logic [AW-1:0]  a_r;
  logic [RW-1:0]  rem_r;
  logic [RTW-1:0] root_r;
  logic [DVW-1:0] den_r;
  logic [CW-1:0]  cnt_r;

  // shared multiply-accumulate unit
  logic signed [ACW-1:0]  acc_r;
  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] prod;
  logic signed [ACW-1:0]  prod_x;
  term_t                  tm;

  // output register
  logic out_valid_r;
  q_t   o_x_r, o_y_r, o_z_r, o_w_r;
  logic o_drag_r;

  logic in_acc;
  logic drag_nxt;

  assign r_eff  = (rad_r == '0) ? REG_BITS'(1) : rad_r;
  assign in_acc = in_item.valid && in_item.ready;
  assign in_item.ready = (state_r == ST_IDLE);

  assign out_item.valid       = out_valid_r;
  assign out_item.rot_x       = o_x_r;
  assign out_item.rot_y       = o_y_r;
  assign out_item.rot_z       = o_z_r;
  assign out_item.rot_w       = o_w_r;
  assign out_item.is_dragging = o_drag_r;

  always_comb begin
    unique case (op_t'(in_item.op))
      OP_BEGIN: drag_nxt = 1'b1;
      OP_END:   drag_nxt = 1'b0;
      default:  drag_nxt = drag_r;
    endcase
  end

  // ---- divide / root step ----
  logic [RW-1:0] cand, sub, diff;
  logic          ge;

  always_comb begin
    if (unit_sqrt_r) begin
      cand = {rem_r[RW-3:0], a_r[AW-1:AW-2]};
      sub  = RW'({root_r, 2'b01});
    end else begin
      cand = {rem_r[RW-2:0], a_r[AW-1]};
      sub  = RW'(den_r);
    end
    ge   = (cand >= sub);
    diff = cand - sub;
  end

  // ---- job operands ----
  logic [COORD_BITS-1:0] adx, ady, amag;
  logic                  jneg;
  logic [AW-1:0]         job_num;
  logic [DVW-1:0]        job_den;
  logic                  job_sqrt;
  logic                  job_last;
  logic [AW-1:0]         q_mag;
  q_t                    q_sat, q_sgn;

  always_comb begin
    logic signed [DW-1:0] nx, ny;
    nx   = -dx_r;
    ny   = -dy_r;
    adx  = dx_r[DW-1] ? nx[COORD_BITS-1:0] : dx_r[COORD_BITS-1:0];
    ady  = dy_r[DW-1] ? ny[COORD_BITS-1:0] : dy_r[COORD_BITS-1:0];
    // x is job 0 inside, job 1 outside
    if ((inside_r && job_r == 2'd0) || (!inside_r && job_r == 2'd1)) begin
      amag = adx;
      jneg = dx_r[DW-1];
    end else begin
      amag = ady;
      jneg = dy_r[DW-1];
    end
    job_sqrt = 1'b0;
    job_num  = '0;
    job_den  = DVW'(r_eff);
    if (inside_r) begin
      job_last = (job_r == 2'd3);
      unique case (job_r)
        2'd0, 2'd1: begin
          job_num = (AW'(amag) << FRAC_BITS) + AW'(r_eff >> 1);
        end
        2'd2: begin
          job_num = AW'(SW'(r2_r) - s_r) << (2 * FRAC_BITS);
          job_den = DVW'(r2_r);
        end
        default: begin
          job_num  = a_r;
          job_sqrt = 1'b1;
        end
      endcase
    end else begin
      job_last = (job_r == 2'd2);
      job_den  = DVW'(n_r);
      unique case (job_r)
        2'd0: begin
          job_num  = AW'(s_r) << (2 * FRAC_BITS);
          job_sqrt = 1'b1;
        end
        default: begin
          job_num = (AW'(amag) << (2 * FRAC_BITS)) + AW'(n_r >> 1);
        end
      endcase
    end
    q_mag = a_r;
    q_sat = (q_mag > AW'(ONE)) ? ONE_Q : q_mag[QW-1:0];
    q_sgn = jneg ? -q_sat : q_sat;
  end

  // ---- multiplier operand select ----
  always_comb begin
    tm = term_tab(phase_r, k_r, j_r);
    unique case (state_r)
      ST_MAC_S: begin
        ma = (j_r == 2'd0) ? MW'(dx_r) : MW'(dy_r);
        mb = ma;
      end
      ST_MAC_R: begin
        ma = MW'($signed({1'b0, r_eff}));
        mb = ma;
      end
      default: begin
        if (phase_r) begin
          ma = MW'(d_r[tm.ai]);
          mb = MW'(down_rot_r[tm.bi]);
        end else begin
          ma = MW'(pick3(ball_r[0][0], ball_r[0][1], ball_r[0][2], tm.ai));
          mb = MW'(pick3(ball_r[1][0], ball_r[1][1], ball_r[1][2], tm.bi));
        end
      end
    endcase
    prod   = ma * mb;
    prod_x = ACW'(prod);
  end

  // ---- sequencer and datapath ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      rad_r       <= REG_BITS'(1);
      drag_r      <= 1'b0;
      now_x_r     <= '0;
      now_y_r     <= '0;
      down_x_r    <= '0;
      down_y_r    <= '0;
      for (int i = 0; i < 4; i++) begin
        down_rot_r[i] <= (i == 3) ? ONE_Q : '0;
        now_rot_r[i]  <= (i == 3) ? ONE_Q : '0;
      end
      unit_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
      pt_r        <= 1'b0;
      job_r       <= '0;
      phase_r     <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CENTER_X: cx_r  <= cfg_wdata;
          CFG_CENTER_Y: cy_r  <= cfg_wdata;
          CFG_RADIUS:   rad_r <= cfg_wdata;
          default: ;
        endcase
      end

      // in the done state the output register is handled there
      if (out_valid_r && out_item.ready && state_r != ST_DONE) out_valid_r <= 1'b0;

      if (unit_busy_r) begin
        rem_r <= ge ? diff : cand;
        if (unit_sqrt_r) begin
          a_r    <= {a_r[AW-3:0], 2'b00};
          root_r <= {root_r[RTW-2:0], ge};
        end else begin
          a_r <= {a_r[AW-2:0], ge};
        end
        if (cnt_r == '0) unit_busy_r <= 1'b0;
        else             cnt_r <= cnt_r - CW'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (op_t'(in_item.op))
              OP_MOVE: begin
                now_x_r <= in_item.pointer_x;
                now_y_r <= in_item.pointer_y;
              end
              OP_BEGIN: begin
                drag_r   <= 1'b1;
                down_x_r <= now_x_r;
                down_y_r <= now_y_r;
              end
              OP_END: begin
                drag_r <= 1'b0;
                for (int i = 0; i < 4; i++) down_rot_r[i] <= now_rot_r[i];
              end
              default: ;
            endcase
            pt_r    <= 1'b0;
            state_r <= drag_nxt ? ST_DELTA : ST_DONE;
          end
        end
        ST_DELTA: begin
          dx_r <= $signed({1'b0, pt_r ? now_x_r : down_x_r}) - $signed({1'b0, cx_r});
          dy_r <= $signed({1'b0, pt_r ? now_y_r : down_y_r}) - $signed({1'b0, cy_r});
          j_r     <= '0;
          state_r <= ST_MAC_S;
        end
        ST_MAC_S: begin
          acc_r <= (j_r == 2'd0) ? prod_x : acc_r + prod_x;
          if (j_r == 2'd1) begin
            state_r <= ST_MAC_R;
          end
          j_r <= j_r + 2'd1;
        end
        ST_MAC_R: begin
          s_r     <= acc_r[SW-1:0];
          acc_r   <= prod_x;
          state_r <= ST_SPLIT;
        end
        ST_SPLIT: begin
          r2_r     <= acc_r[R2W-1:0];
          inside_r <= (s_r <= SW'(acc_r[R2W-1:0]));
          job_r    <= '0;
          state_r  <= ST_JOB;
        end
        ST_JOB: begin
          a_r         <= job_num;
          den_r       <= job_den;
          unit_sqrt_r <= job_sqrt;
          rem_r       <= '0;
          root_r      <= '0;
          cnt_r       <= job_sqrt ? CW'(RTW - 1) : CW'(AW - 1);
          unit_busy_r <= 1'b1;
          state_r     <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!unit_busy_r) begin
            if (inside_r) begin
              unique case (job_r)
                2'd0:    ball_r[pt_r][0] <= q_sgn;
                2'd1:    ball_r[pt_r][1] <= q_sgn;
                2'd2:    ;
                default: begin
                  ball_r[pt_r][2] <= (root_r > RTW'(ONE)) ? ONE_Q : root_r[QW-1:0];
                end
              endcase
            end else begin
              unique case (job_r)
                2'd0: n_r <= (root_r == '0) ? RTW'(1) : root_r;
                2'd1: ball_r[pt_r][0] <= q_sgn;
                default: begin
                  ball_r[pt_r][1] <= q_sgn;
                  ball_r[pt_r][2] <= '0;
                end
              endcase
            end
            job_r <= job_r + 2'd1;
            if (!job_last) begin
              state_r <= ST_JOB;
            end else if (!pt_r) begin
              pt_r    <= 1'b1;
              state_r <= ST_DELTA;
            end else begin
              phase_r <= 1'b0;
              k_r     <= '0;
              j_r     <= '0;
              state_r <= ST_PROD;
            end
          end
        end
        ST_PROD: begin
          acc_r <= ((j_r == 2'd0) ? '0 : acc_r) +
                   (tm.en ? (tm.neg ? -prod_x : prod_x) : '0);
          j_r   <= j_r + 2'd1;
          if (j_r == 2'd3) state_r <= ST_WB;
        end
        ST_WB: begin
          if (phase_r) now_rot_r[k_r] <= round_q(acc_r);
          else         d_r[k_r]       <= round_q(acc_r);
          k_r <= k_r + 2'd1;
          if (k_r != 2'd3)  state_r <= ST_PROD;
          else if (!phase_r) begin
            phase_r <= 1'b1;
            state_r <= ST_PROD;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_item.ready) begin
            out_valid_r <= 1'b1;
            o_x_r       <= -now_rot_r[0];
            o_y_r       <= -now_rot_r[1];
            o_z_r       <= -now_rot_r[2];
            o_w_r       <= now_rot_r[3];
            o_drag_r    <= drag_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ---- assertions ----
  a_end_clears_drag: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.op == OP_END |=> !drag_r)
    else $error("drag still active after end transaction");

  a_unit_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_busy_r |-> state_r == ST_WAIT)
    else $error("divide/root unit busy outside wait state");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  a_rot_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    now_rot_r[3] <= ONE_Q && now_rot_r[3] >= -ONE_Q)
    else $error("rotation scalar out of range");

endmodule

[dv/art_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_checker
// Watches the operation, result and register ports of the arcball tracker,
// predicts each result in Q2.14 and compares it with what the block returns.
// ----------------------------------------------------------------------------
module art_checker import art_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  art_in_if                    in_mon,
  art_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_BITS-1:0]  cfg_wdata,
  output int                   fail_count
);

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  typedef struct {
    q_t   x;
    q_t   y;
    q_t   z;
    q_t   w;
    logic drag;
  } pose_t;

  pose_t pose_q[$];
  int    mismatches;

  logic [REG_BITS-1:0] ctr_x, ctr_y, radius;
  logic                drag_on;
  coord_t              cur_x, cur_y, anchor_x, anchor_y;
  longint              anchor_rot[4];
  longint              cur_rot[4];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // half away from zero, den > 0
  function automatic longint div_away(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint clip_one(longint v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  function automatic longint to_q(longint v);
    return clip_one((v + (ONE_Q >>> 1)) >>> FRAC_BITS);
  endfunction

  function automatic void ball_point(coord_t px, coord_t py,
                                     output longint bx, output longint by,
                                     output longint bz);
    longint r, dx, dy, s, r2, n;
    longint unsigned q;
    r  = (radius == 0) ? 1 : longint'(radius);
    dx = longint'(px) - longint'(ctr_x);
    dy = longint'(py) - longint'(ctr_y);
    s  = dx * dx + dy * dy;
    r2 = r * r;
    if (s > r2) begin
      // beyond the rim: normalize onto the equator
      n = longint'(int_sqrt(longint'(s) << (2 * FRAC_BITS)));
      if (n < 1) n = 1;
      bx = clip_one(div_away(dx * ONE_Q * ONE_Q, n));
      by = clip_one(div_away(dy * ONE_Q * ONE_Q, n));
      bz = 0;
    end else begin
      q  = (longint'(r2 - s) << (2 * FRAC_BITS)) / r2;
      bx = clip_one(div_away(dx * ONE_Q, r));
      by = clip_one(div_away(dy * ONE_Q, r));
      bz = clip_one(longint'(int_sqrt(q)));
    end
  endfunction

  function automatic void track_drag();
    longint f[3], t[3], d[4], e[4];
    if (!drag_on) return;
    ball_point(anchor_x, anchor_y, f[0], f[1], f[2]);
    ball_point(cur_x, cur_y, t[0], t[1], t[2]);
    d[0] = to_q(f[1] * t[2] - f[2] * t[1]);
    d[1] = to_q(f[2] * t[0] - f[0] * t[2]);
    d[2] = to_q(f[0] * t[1] - f[1] * t[0]);
    d[3] = to_q(f[0] * t[0] + f[1] * t[1] + f[2] * t[2]);
    e = anchor_rot;
    cur_rot[3] = to_q(d[3] * e[3] - d[0] * e[0] - d[1] * e[1] - d[2] * e[2]);
    cur_rot[0] = to_q(d[3] * e[0] + d[0] * e[3] + d[1] * e[2] - d[2] * e[1]);
    cur_rot[1] = to_q(d[3] * e[1] - d[0] * e[2] + d[1] * e[3] + d[2] * e[0]);
    cur_rot[2] = to_q(d[3] * e[2] + d[0] * e[1] - d[1] * e[0] + d[2] * e[3]);
  endfunction

  function automatic pose_t apply_op(op_code_t op, coord_t px, coord_t py);
    pose_t p;
    if (op == OP_MOVE) begin
      cur_x = px;
      cur_y = py;
    end else if (op == OP_BEGIN) begin
      drag_on  = 1'b1;
      anchor_x = cur_x;
      anchor_y = cur_y;
    end else if (op == OP_END) begin
      drag_on    = 1'b0;
      anchor_rot = cur_rot;
    end
    track_drag();
    p.x    = q_t'(-cur_rot[0]);
    p.y    = q_t'(-cur_rot[1]);
    p.z    = q_t'(-cur_rot[2]);
    p.w    = q_t'(cur_rot[3]);
    p.drag = drag_on;
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      ctr_x      <= '0;
      ctr_y      <= '0;
      radius     <= REG_BITS'(1);
      drag_on     = 1'b0;
      cur_x       = '0;
      cur_y       = '0;
      anchor_x    = '0;
      anchor_y    = '0;
      anchor_rot  = '{0, 0, 0, ONE_Q};
      cur_rot     = '{0, 0, 0, ONE_Q};
      mismatches  = 0;
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: ctr_x  <= cfg_wdata;
          CFG_CENTER_Y: ctr_y  <= cfg_wdata;
          CFG_RADIUS:   radius <= cfg_wdata;
          default: ;
        endcase
      end
      // result first: it can never belong to an item accepted at this edge
      if (out_mon.valid && out_mon.ready) begin
        if (pose_q.size() == 0) begin
          $error("unexpected result transaction");
          mismatches++;
        end else begin
          want = pose_q.pop_front();
          if (out_mon.rot_x !== want.x) begin
            $error("rot_x exp %0d got %0d", want.x, out_mon.rot_x);
            mismatches++;
          end
          if (out_mon.rot_y !== want.y) begin
            $error("rot_y exp %0d got %0d", want.y, out_mon.rot_y);
            mismatches++;
          end
          if (out_mon.rot_z !== want.z) begin
            $error("rot_z exp %0d got %0d", want.z, out_mon.rot_z);
            mismatches++;
          end
          if (out_mon.rot_w !== want.w) begin
            $error("rot_w exp %0d got %0d", want.w, out_mon.rot_w);
            mismatches++;
          end
          if (out_mon.is_dragging !== want.drag) begin
            $error("is_dragging exp %0b got %0b", want.drag, out_mon.is_dragging);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pose_q.push_back(apply_op(in_mon.op, in_mon.pointer_x, in_mon.pointer_y));
    end
    fail_count <= mismatches + pose_q.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the arcball tracker: directed corner cases, then drag
// sequences with random pointer paths over several ball settings, with
// random idling of the sender and back-pressure from the receiver.
// ----------------------------------------------------------------------------
module tb;
  import art_pkg::*;

  localparam op_code_t OP_UNUSED = 2'd3;
  localparam int       WATCHDOG  = 20000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_BITS-1:0]  cfg_wdata;
  int                   fail_count;

  art_in_if  in_item ();
  art_out_if out_item ();

  arcball_rotation_tracker_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  art_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_item),
    .out_mon   (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count)
  );

  int   ops_sent, poses_seen, drags_begun, settings_used, idle_cycles;
  bit   calm;
  bit   hold_req;
  int   hold_left;
  int   ctr_x, ctr_y, rad;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off when requested
  initial begin
    out_item.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_item.ready <= 1'b0;
      end else begin
        out_item.ready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    if (out_item.valid && out_item.ready) poses_seen++;
    if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_op(op_code_t op, int px, int py);
    if (!calm && $urandom_range(0, 99) < 27) begin
      in_item.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_item.valid     <= 1'b1;
    in_item.op        <= op;
    in_item.pointer_x <= coord_t'(px);
    in_item.pointer_y <= coord_t'(py);
    @(posedge clk iff (in_item.valid && in_item.ready));
    ops_sent++;
    if (op == OP_BEGIN) drags_begun++;
  endtask

  task automatic drain();
    in_item.valid <= 1'b0;
    @(posedge clk);
    while (poses_seen != ops_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_ball(int cx, int cy, int r);
    ctr_x = cx;
    ctr_y = cy;
    rad   = r;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CENTER_X;
    cfg_wdata <= REG_BITS'(cx);
    @(posedge clk);
    cfg_index <= CFG_CENTER_Y;
    cfg_wdata <= REG_BITS'(cy);
    @(posedge clk);
    cfg_index <= CFG_RADIUS;
    cfg_wdata <= REG_BITS'(r);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // pointer around the ball, reaching somewhat past the rim
  task automatic move_near();
    int span, px, py;
    span = (rad == 0 ? 1 : rad) * 13 / 10 + 1;
    if ($urandom_range(0, 9) == 0) begin
      px = $urandom_range(0, 4095);
      py = $urandom_range(0, 4095);
    end else begin
      px = ctr_x + $urandom_range(0, 2 * span) - span;
      py = ctr_y + $urandom_range(0, 2 * span) - span;
      px = px < 0 ? 0 : (px > 4095 ? 4095 : px);
      py = py < 0 ? 0 : (py > 4095 ? 4095 : py);
    end
    send_op(OP_MOVE, px, py);
  endtask

  initial begin
    int phase, stop_at, k;
    ops_sent = 0; poses_seen = 0; drags_begun = 0; settings_used = 0;
    calm = 1'b0; hold_req = 1'b0; idle_cycles = 0;
    ctr_x = 0; ctr_y = 0; rad = 1;
    rst_n             <= 1'b0;
    in_item.valid     <= 1'b0;
    in_item.op        <= OP_MOVE;
    in_item.pointer_x <= '0;
    in_item.pointer_y <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_CENTER_X;
    cfg_wdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then a centered ball and a zero radius
    send_op(OP_MOVE, 0, 0);
    send_op(OP_END, 0, 0);            // end with no drag in progress
    send_op(OP_BEGIN, 0, 0);
    send_op(OP_MOVE, 4095, 4095);
    send_op(OP_MOVE, 0, 1);
    send_op(OP_UNUSED, 4095, 0);
    send_op(OP_END, 0, 0);
    drain();
    set_ball(2048, 2048, 4095);
    send_op(OP_MOVE, 2048, 2048);
    send_op(OP_BEGIN, 0, 0);
    send_op(OP_MOVE, 4095, 0);
    send_op(OP_MOVE, 0, 4095);
    send_op(OP_BEGIN, 0, 0);          // re-anchor while dragging
    send_op(OP_MOVE, 2048, 4095);
    send_op(OP_END, 0, 0);
    send_op(OP_MOVE, 100, 100);       // move without drag keeps rotation
    drain();
    set_ball(4095, 0, 0);             // zero radius behaves as one
    send_op(OP_MOVE, 4095, 0);
    send_op(OP_BEGIN, 0, 0);
    send_op(OP_MOVE, 4094, 1);
    send_op(OP_MOVE, 0, 4095);
    send_op(OP_END, 0, 0);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_ball(2048, 2048, 600);
        1: set_ball(0, 0, 1);
        2: set_ball(4095, 4095, 4095);
        3: set_ball($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(1, 64));
        4: set_ball($urandom_range(1000, 3000), $urandom_range(1000, 3000),
                    $urandom_range(100, 1500));
        default: set_ball($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(1, 4095));
      endcase
      calm = (phase == 4);
      if (phase == 2) hold_req = 1'b1;   // fill the block, stall its input
      stop_at = ops_sent + 250;
      while (ops_sent < stop_at) begin
        if ($urandom_range(0, 99) < 80) begin
          move_near();
          send_op(OP_BEGIN, 0, 0);
          k = $urandom_range(1, 4);
          repeat (k) move_near();
          send_op(OP_END, $urandom_range(0, 4095), $urandom_range(0, 4095));
        end else begin
          send_op(op_code_t'($urandom_range(0, 3)),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
        end
      end
      calm = 1'b0;
      drain();   // sender waits for every result before the next setting
    end

    repeat (600) @(posedge clk);
    $display("covered %0d operations, %0d drags, %0d ball settings",
             ops_sent, drags_begun, settings_used);
    $display("results checked: %0d", poses_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/art_pkg.sv
hw/rtl/art_in_if.sv
hw/rtl/art_out_if.sv
hw/rtl/arcball_rotation_tracker_unit.sv
dv/art_checker.sv
dv/tb.sv
